@@ design/spiral_order_sort_defines.svh @@
// assertion macros for the spiral order sort block
`ifndef SPIRAL_ORDER_SORT_DEFINES_SVH
`define SPIRAL_ORDER_SORT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SOS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SOS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/sos_pkg.sv @@
// shared types and constants for the spiral order sort block
`timescale 1ns / 1ps
package sos_pkg;

    // default sizes
    localparam int DEF_MAX_ROWS = 16;
    localparam int DEF_MAX_COLS = 16;
    localparam int DEF_DATA_W   = 32;

    // fixed field widths
    localparam int POS_W      = 4;
    localparam int CFG_DATA_W = 5;
    localparam int CFG_IDX_W  = 2;

    // register reset values
    localparam logic [CFG_DATA_W-1:0] RST_ROWS = 5'd4;
    localparam logic [CFG_DATA_W-1:0] RST_COLS = 5'd4;

    // item operation codes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_UNLOAD = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS = 2'd0,
        CFG_COLS = 2'd1
    } cfg_reg_t;

    // spiral walk phase
    typedef enum logic [1:0] {
        PH_TOP    = 2'd0,
        PH_RIGHT  = 2'd1,
        PH_BOTTOM = 2'd2,
        PH_LEFT   = 2'd3
    } phase_t;

    // control broadcast to every sort cell
    typedef struct packed {
        logic load;
        logic unload;
    } cell_ctrl_t;

endpackage

@@ design/sos_cell.sv @@
// one cell of the insertion sort chain
`timescale 1ns / 1ps
module sos_cell #(
    parameter int DATA_W = sos_pkg::DEF_DATA_W,
    parameter int CNT_W  = 9,
    parameter int INDEX  = 0
) (
    input  logic                     clk,
    input  sos_pkg::cell_ctrl_t      ctrl,
    input  logic signed [DATA_W-1:0] ins_value,
    input  logic signed [DATA_W-1:0] prev_value,
    input  logic signed [DATA_W-1:0] next_value,
    input  logic                     prev_gt,
    input  logic [CNT_W-1:0]         fill,
    output logic signed [DATA_W-1:0] value,
    output logic                     gt
);
    import sos_pkg::*;

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;
    logic                     occupied;
    logic                     at_tail;

    // position of this cell against the fill level
    assign occupied = CNT_W'(INDEX) < fill;
    assign at_tail  = CNT_W'(INDEX) == fill;

    // strictly greater keeps equal values in arrival order
    assign gt = occupied && (value_reg > ins_value);

    // insert: take left neighbor, take new value, or hold; unload: shift toward head
    always_comb
    begin
        value_next = value_reg;
        if (ctrl.load)
        begin
            if (prev_gt)
            begin
                value_next = prev_value;
            end
            else if (gt || at_tail)
            begin
                value_next = ins_value;
            end
        end
        else if (ctrl.unload)
        begin
            value_next = next_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

@@ design/sos_walk.sv @@
// clockwise spiral position walker
`timescale 1ns / 1ps
module sos_walk #(
    parameter int RW = 4,
    parameter int CW = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fresh,
    input  logic          step,
    input  logic [RW-1:0] rows_m1,
    input  logic [CW-1:0] cols_m1,
    output logic [RW-1:0] row,
    output logic [CW-1:0] col
);
    import sos_pkg::*;

    phase_t        phase_reg,  phase_next;
    logic [RW-1:0] top_reg,    top_next;
    logic [RW-1:0] bottom_reg, bottom_next;
    logic [CW-1:0] left_reg,   left_next;
    logic [CW-1:0] right_reg,  right_next;
    logic [RW-1:0] row_reg,    row_next;
    logic [CW-1:0] col_reg,    col_next;

    phase_t        e_phase;
    logic [RW-1:0] e_top, e_bottom, e_row;
    logic [CW-1:0] e_left, e_right, e_col;

    // first place of a matrix starts from the configured geometry
    always_comb
    begin
        e_phase  = fresh ? PH_TOP   : phase_reg;
        e_top    = fresh ? '0       : top_reg;
        e_bottom = fresh ? rows_m1  : bottom_reg;
        e_left   = fresh ? '0       : left_reg;
        e_right  = fresh ? cols_m1  : right_reg;
        e_row    = fresh ? '0       : row_reg;
        e_col    = fresh ? '0       : col_reg;
    end

    assign row = e_row;
    assign col = e_col;

    // next place along the spiral
    always_comb
    begin
        phase_next  = e_phase;
        top_next    = e_top;
        bottom_next = e_bottom;
        left_next   = e_left;
        right_next  = e_right;
        row_next    = e_row;
        col_next    = e_col;
        case (e_phase)
            PH_TOP:
            begin
                if (e_col < e_right)
                begin
                    col_next = e_col + 1'b1;
                end
                else
                begin
                    top_next   = e_top + 1'b1;
                    phase_next = PH_RIGHT;
                    row_next   = e_row + 1'b1;
                end
            end
            PH_RIGHT:
            begin
                if (e_row < e_bottom)
                begin
                    row_next = e_row + 1'b1;
                end
                else
                begin
                    right_next = e_right - 1'b1;
                    phase_next = PH_BOTTOM;
                    col_next   = e_col - 1'b1;
                end
            end
            PH_BOTTOM:
            begin
                if (e_col > e_left)
                begin
                    col_next = e_col - 1'b1;
                end
                else
                begin
                    bottom_next = e_bottom - 1'b1;
                    phase_next  = PH_LEFT;
                    row_next    = e_row - 1'b1;
                end
            end
            PH_LEFT:
            begin
                if (e_row > e_top)
                begin
                    row_next = e_row - 1'b1;
                end
                else
                begin
                    left_next  = e_left + 1'b1;
                    phase_next = PH_TOP;
                    col_next   = e_col + 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_TOP;
            end
        endcase
    end

    // walk state, moves once per result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_TOP;
            top_reg    <= '0;
            bottom_reg <= '0;
            left_reg   <= '0;
            right_reg  <= '0;
            row_reg    <= '0;
            col_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            top_reg    <= top_next;
            bottom_reg <= bottom_next;
            left_reg   <= left_next;
            right_reg  <= right_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
        end
    end

endmodule

@@ design/spiral_order_sort.sv @@
// spiral order sort: insertion sort chain with clockwise spiral placement
// an unload item shows its result in the output register in the cycle after it is accepted
// one item per cycle, loads and unloads alike; only a stalled output register holds the input
// a load is inserted by the row of compare cells in the cycle it is accepted
// reset clears counts, configuration (4 rows, 4 columns) and output valid; no clearing pass
`timescale 1ns / 1ps
`include "spiral_order_sort_defines.svh"
module spiral_order_sort #(
    parameter int MAX_ROWS   = sos_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS   = sos_pkg::DEF_MAX_COLS,
    parameter int DATA_WIDTH = sos_pkg::DEF_DATA_W
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // item input
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  operation,
    input  logic signed [DATA_WIDTH-1:0]          value,
    // result output
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [sos_pkg::POS_W-1:0]             row,
    output logic [sos_pkg::POS_W-1:0]             col,
    output logic signed [DATA_WIDTH-1:0]          sorted_value,
    output logic                                  last,
    // configuration writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [sos_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [sos_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import sos_pkg::*;

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int CNT_W = $clog2(CELLS + 1);
    localparam int RN_W  = $clog2(MAX_ROWS + 1);
    localparam int CN_W  = $clog2(MAX_COLS + 1);
    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    logic [CFG_DATA_W-1:0]   rows_reg, cols_reg;
    logic [CNT_W-1:0]        fill_reg, fill_next;
    logic [CNT_W-1:0]        emitted_reg, emitted_next;
    logic [CNT_W-1:0]        total_reg, total_next;
    logic                    out_valid_reg;
    logic [POS_W-1:0]        row_reg, col_reg;
    logic signed [DATA_WIDTH-1:0] value_reg;
    logic                    last_reg;

    logic [RN_W-1:0]         rows_eff;
    logic [CN_W-1:0]         cols_eff;
    logic [RW-1:0]           rows_m1;
    logic [CW-1:0]           cols_m1;
    logic [CNT_W-1:0]        cap;
    logic [CNT_W-1:0]        total_eff;
    logic                    fresh;
    logic                    in_fire;
    logic                    is_load;
    logic                    do_load;
    logic                    do_unload;
    logic                    fin;
    logic [RW-1:0]           walk_row;
    logic [CW-1:0]           walk_col;
    cell_ctrl_t              ctrl;

    logic signed [DATA_WIDTH-1:0] cell_value [CELLS];
    logic                         cell_gt    [CELLS];

    // configuration port, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= RST_ROWS;
            cols_reg <= RST_COLS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ROWS: rows_reg <= cfg_data;
                CFG_COLS: cols_reg <= cfg_data;
                default:  ;
            endcase
        end
    end

    // geometry clamped to the supported range
    always_comb
    begin
        if (rows_reg == '0)
        begin
            rows_eff = RN_W'(1);
        end
        else if (32'(rows_reg) > 32'(MAX_ROWS))
        begin
            rows_eff = RN_W'(MAX_ROWS);
        end
        else
        begin
            rows_eff = RN_W'(rows_reg);
        end
        if (cols_reg == '0)
        begin
            cols_eff = CN_W'(1);
        end
        else if (32'(cols_reg) > 32'(MAX_COLS))
        begin
            cols_eff = CN_W'(MAX_COLS);
        end
        else
        begin
            cols_eff = CN_W'(cols_reg);
        end
    end

    assign rows_m1 = RW'(rows_eff - RN_W'(1));
    assign cols_m1 = CW'(cols_eff - CN_W'(1));
    assign cap     = CNT_W'(CNT_W'(rows_eff) * CNT_W'(cols_eff));

    // item handshake and decode
    assign in_stall  = out_valid_reg && out_stall;
    assign in_fire   = in_valid && !in_stall;
    assign is_load   = (operation == OP_LOAD);
    assign fresh     = (emitted_reg == '0);
    assign do_load   = in_fire && is_load && fresh && (fill_reg < cap);
    assign do_unload = in_fire && !is_load && (fill_reg != '0);
    assign total_eff = fresh ? cap : total_reg;
    assign fin       = ({1'b0, emitted_reg} + 1'b1) >= {1'b0, total_eff};

    assign ctrl.load   = do_load;
    assign ctrl.unload = do_unload;

    // row of sort cells, head holds the smallest value
    genvar gi;
    generate
        for (gi = 0; gi < CELLS; gi++)
        begin : g_cell
            logic signed [DATA_WIDTH-1:0] prev_value;
            logic signed [DATA_WIDTH-1:0] next_value;
            logic                         prev_gt;

            if (gi == 0)
            begin : g_head
                assign prev_value = cell_value[gi];
                assign prev_gt    = 1'b0;
            end
            else
            begin : g_body
                assign prev_value = cell_value[gi-1];
                assign prev_gt    = cell_gt[gi-1];
            end

            if (gi == CELLS - 1)
            begin : g_tail
                assign next_value = cell_value[gi];
            end
            else
            begin : g_link
                assign next_value = cell_value[gi+1];
            end

            sos_cell #(
                .DATA_W (DATA_WIDTH),
                .CNT_W  (CNT_W),
                .INDEX  (gi)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .ins_value  (value),
                .prev_value (prev_value),
                .next_value (next_value),
                .prev_gt    (prev_gt),
                .fill       (fill_reg),
                .value      (cell_value[gi]),
                .gt         (cell_gt[gi])
            );
        end
    endgenerate

    // spiral position of the next result
    sos_walk #(
        .RW (RW),
        .CW (CW)
    ) u_walk (
        .clk     (clk),
        .rst_n   (rst_n),
        .fresh   (fresh),
        .step    (do_unload),
        .rows_m1 (rows_m1),
        .cols_m1 (cols_m1),
        .row     (walk_row),
        .col     (walk_col)
    );

    // fill and emitted counts
    always_comb
    begin
        fill_next    = fill_reg;
        emitted_next = emitted_reg;
        total_next   = total_reg;
        if (do_load)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_unload)
        begin
            if (fin)
            begin
                fill_next    = '0;
                emitted_next = '0;
            end
            else
            begin
                fill_next    = fill_reg - 1'b1;
                emitted_next = emitted_reg + 1'b1;
                total_next   = total_eff;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            emitted_reg <= '0;
            total_reg   <= '0;
        end
        else
        begin
            fill_reg    <= fill_next;
            emitted_reg <= emitted_next;
            total_reg   <= total_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (do_unload)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_unload)
        begin
            row_reg   <= POS_W'(walk_row);
            col_reg   <= POS_W'(walk_col);
            value_reg <= cell_value[0];
            last_reg  <= fin;
        end
    end

    assign out_valid    = out_valid_reg;
    assign row          = row_reg;
    assign col          = col_reg;
    assign sorted_value = value_reg;
    assign last         = last_reg;

    // checks
    `SOS_ASSERT_IMPL(a_count_bound, 1'b1, (32'(fill_reg) + 32'(emitted_reg) <= 32'(CELLS)), "fill and emitted counts exceed the cell row")
    `SOS_ASSERT_NEXT(a_last_empties, (do_unload && fin), (fill_reg == '0 && emitted_reg == '0), "block not empty after the last item")
    `SOS_ASSERT_NEXT(a_emit_count, (do_unload && !fin), (emitted_reg == $past(emitted_reg) + 1'b1), "emitted count did not advance")
    `SOS_ASSERT_NEXT(a_load_locked, (in_fire && is_load && !fresh), $stable(fill_reg), "load accepted while unloading")

endmodule

@@ tb/sv/tb_spiral_order_sort.sv @@
// self-checking testbench for the spiral order sort block
`timescale 1ns / 1ps
module tb_spiral_order_sort;
    import sos_pkg::*;

    localparam int MAX_R      = DEF_MAX_ROWS;
    localparam int MAX_C      = DEF_MAX_COLS;
    localparam int DW         = DEF_DATA_W;
    localparam int QUIET_MAX  = 2000;
    localparam int HOLD_LEN   = 300;

    // one expected unload result
    typedef struct {
        logic [POS_W-1:0]    row;
        logic [POS_W-1:0]    col;
        logic signed [DW-1:0] val;
        logic                fin;
    } place_t;

    // sorted store plus spiral walk, and the queue of places still to come out
    class place_checker;
        logic [CFG_DATA_W-1:0] rows_reg;
        logic [CFG_DATA_W-1:0] cols_reg;
        logic signed [DW-1:0]  cells [MAX_R*MAX_C];
        int                    stored;
        int                    emitted;
        int                    walk_total;
        int                    b_top;
        int                    b_bot;
        int                    b_lft;
        int                    b_rgt;
        phase_t                phase;
        int                    cur_r;
        int                    cur_c;
        place_t                due [$];
        int                    errors;

        function new();
            rows_reg = RST_ROWS;
            cols_reg = RST_COLS;
            errors   = 0;
            empty_all();
        endfunction

        // zero counts to one, oversize clamps to the maximum
        function int eff_dim(logic [CFG_DATA_W-1:0] v, int maxd);
            if (v == 0)
                return 1;
            if (int'(v) > maxd)
                return maxd;
            return int'(v);
        endfunction

        function void start_walk();
            b_top      = 0;
            b_lft      = 0;
            b_bot      = eff_dim(rows_reg, MAX_R) - 1;
            b_rgt      = eff_dim(cols_reg, MAX_C) - 1;
            phase      = PH_TOP;
            cur_r      = 0;
            cur_c      = 0;
            walk_total = eff_dim(rows_reg, MAX_R) * eff_dim(cols_reg, MAX_C);
        endfunction

        function void empty_all();
            stored  = 0;
            emitted = 0;
            start_walk();
        endfunction

        // clockwise step, turning inward at each bound
        function void step_walk();
            case (phase)
                PH_TOP:
                begin
                    if (cur_c < b_rgt)
                        cur_c++;
                    else
                    begin
                        b_top++;
                        phase = PH_RIGHT;
                        cur_r++;
                    end
                end
                PH_RIGHT:
                begin
                    if (cur_r < b_bot)
                        cur_r++;
                    else
                    begin
                        b_rgt--;
                        phase = PH_BOTTOM;
                        cur_c--;
                    end
                end
                PH_BOTTOM:
                begin
                    if (cur_c > b_lft)
                        cur_c--;
                    else
                    begin
                        b_bot--;
                        phase = PH_LEFT;
                        cur_r--;
                    end
                end
                default:
                begin
                    if (cur_r > b_top)
                        cur_r--;
                    else
                    begin
                        b_lft++;
                        phase = PH_TOP;
                        cur_c++;
                    end
                end
            endcase
        endfunction

        function void note_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            if (idx == CFG_ROWS)
                rows_reg = d;
            else if (idx == CFG_COLS)
                cols_reg = d;
        endfunction

        // accepted input item: insert a load or queue the next spiral place
        function void note_item(logic op, logic signed [DW-1:0] v);
            int     cap;
            int     k;
            place_t p;
            if (op == OP_LOAD)
            begin
                cap = eff_dim(rows_reg, MAX_R) * eff_dim(cols_reg, MAX_C);
                if (emitted != 0 || stored >= cap)
                    return;
                k = stored;
                while (k > 0 && cells[k-1] > v)
                begin
                    cells[k] = cells[k-1];
                    k--;
                end
                cells[k] = v;
                stored++;
                return;
            end
            if (emitted >= stored)
                return;
            if (emitted == 0)
                start_walk();
            p.row = 4'(cur_r);
            p.col = 4'(cur_c);
            p.val = cells[emitted];
            p.fin = (emitted + 1 >= walk_total);
            due.push_back(p);
            if (p.fin)
                empty_all();
            else
            begin
                emitted++;
                step_walk();
            end
        endfunction

        // accepted result against the oldest pending place
        function void check_place(logic [POS_W-1:0] r, logic [POS_W-1:0] c,
                                  logic signed [DW-1:0] v, logic l);
            place_t e;
            if (due.size() == 0)
            begin
                $error("unexpected result: row %0d col %0d value %0d last %0d", r, c, v, l);
                errors++;
                return;
            end
            e = due.pop_front();
            if (r !== e.row)
            begin
                $error("row mismatch: expected %0d, got %0d", e.row, r);
                errors++;
            end
            if (c !== e.col)
            begin
                $error("col mismatch: expected %0d, got %0d", e.col, c);
                errors++;
            end
            if (v !== e.val)
            begin
                $error("sorted_value mismatch: expected %0d, got %0d", e.val, v);
                errors++;
            end
            if (l !== e.fin)
            begin
                $error("last mismatch: expected %0d, got %0d", e.fin, l);
                errors++;
            end
        endfunction

        function int close_out();
            foreach (due[i])
                $error("missing result: row %0d col %0d value %0d", due[i].row, due[i].col,
                       due[i].val);
            errors += due.size();
            return errors;
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic                     operation = OP_LOAD;
    logic signed [DW-1:0]     value = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [POS_W-1:0]         row;
    logic [POS_W-1:0]         col;
    logic signed [DW-1:0]     sorted_value;
    logic                     last;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = CFG_ROWS;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;

    place_checker             places;
    logic [CFG_DATA_W-1:0]    rows_now = RST_ROWS;
    logic [CFG_DATA_W-1:0]    cols_now = RST_COLS;
    bit                       steady = 1'b0;
    bit                       hold_req = 1'b0;
    int                       hold_left = 0;
    int                       quiet_cycles = 0;
    int                       work_items = 0;

    spiral_order_sort uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .row          (row),
        .col          (col),
        .sorted_value (sorted_value),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    // receiver: random stalls, or a long hold-off when asked
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_LEN;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !steady && ($urandom_range(0, 99) < 10);
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                places.check_place(row, col, sorted_value, last);
            if (in_valid && !in_stall)
                places.note_item(operation, value);
            if (cfg_valid && cfg_ready)
                places.note_reg(cfg_index, cfg_data);
            if ((out_valid && !out_stall) || (in_valid && !in_stall) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_MAX)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // full range, small duplicates, extremes or mid range
    function automatic logic signed [DW-1:0] rand_value();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return $urandom();
        if (pick < 7)
            return DW'(int'($urandom_range(0, 8)) - 4);
        if (pick == 7)
        begin
            case ($urandom_range(0, 3))
                0: return 32'sh8000_0000;
                1: return 32'sh7FFF_FFFF;
                2: return 32'sh0000_0000;
                default: return 32'shFFFF_FFFF;
            endcase
        end
        return DW'(int'($urandom_range(0, 65535)) - 32768);
    endfunction

    // mostly small dimensions, sometimes zero, oversize or mid
    function automatic logic [CFG_DATA_W-1:0] pick_dim();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            return '0;
        if (pick < 14)
            return CFG_DATA_W'($urandom_range(17, 31));
        if (pick < 20)
            return CFG_DATA_W'($urandom_range(5, 16));
        return CFG_DATA_W'($urandom_range(1, 4));
    endfunction

    // offer one item, leaving valid high after acceptance
    task automatic send_item(input logic op, input logic signed [DW-1:0] v);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(0, 99) < 10)
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 6) : 1;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        operation <= op;
        value     <= v;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
    endtask

    // stop sending and let every pending result come out
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (places.due.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] d);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_ROWS)
            rows_now = d;
        else
            cols_now = d;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // one matrix: optional new size, loads, optional shrink, then the spiral unload
    task automatic run_matrix(input bit new_size, input logic [CFG_DATA_W-1:0] r,
                              input logic [CFG_DATA_W-1:0] c, input bit shrink, input bit hold);
        int cap;
        int walk;
        int er;
        int ec;
        int nr;
        int nc;
        if (new_size)
        begin
            wait_idle();
            cfg_write(CFG_ROWS, r);
            cfg_write(CFG_COLS, c);
        end
        er   = places.eff_dim(rows_now, MAX_R);
        ec   = places.eff_dim(cols_now, MAX_C);
        cap  = er * ec;
        walk = cap;
        // unload with an empty store
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 2)) send_item(OP_UNLOAD, rand_value());
        for (int i = 0; i < cap; i++)
        begin
            send_item(OP_LOAD, rand_value());
            work_items++;
        end
        // loads past a full store
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) send_item(OP_LOAD, rand_value());
        // smaller spiral than what was stored
        if (shrink)
        begin
            nr = $urandom_range(1, er);
            nc = $urandom_range(1, ec);
            wait_idle();
            cfg_write(CFG_ROWS, CFG_DATA_W'(nr));
            cfg_write(CFG_COLS, CFG_DATA_W'(nc));
            walk = nr * nc;
        end
        if (hold)
            hold_req = 1'b1;
        for (int i = 0; i < walk; i++)
        begin
            // loads while unloading are dropped
            if (i > 0 && $urandom_range(0, 9) == 0)
                send_item(OP_LOAD, rand_value());
            send_item(OP_UNLOAD, rand_value());
            work_items++;
        end
        if ($urandom_range(0, 4) == 0)
            send_item(OP_UNLOAD, rand_value());
    endtask

    // stimulus
    initial
    begin
        logic [CFG_DATA_W-1:0] r;
        logic [CFG_DATA_W-1:0] c;
        places = new();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty store, extremes on a 2x2, full store, load during unload
        send_item(OP_UNLOAD, rand_value());
        wait_idle();
        cfg_write(CFG_ROWS, 5'd2);
        cfg_write(CFG_COLS, 5'd2);
        send_item(OP_LOAD, 32'sh7FFF_FFFF);
        send_item(OP_LOAD, 32'sh8000_0000);
        send_item(OP_LOAD, 32'sh0000_0000);
        send_item(OP_LOAD, 32'shFFFF_FFFF);
        send_item(OP_LOAD, 32'sd5);
        send_item(OP_UNLOAD, 32'sh0000_0000);
        send_item(OP_LOAD, 32'sd9);
        send_item(OP_UNLOAD, 32'shFFFF_FFFF);
        send_item(OP_UNLOAD, 32'sh0000_0000);
        send_item(OP_UNLOAD, 32'shFFFF_FFFF);
        send_item(OP_UNLOAD, 32'sh0000_0000);

        // 3x3 with duplicates, then a zero-row shrink drops the rest
        wait_idle();
        cfg_write(CFG_ROWS, 5'd3);
        cfg_write(CFG_COLS, 5'd3);
        send_item(OP_LOAD, 32'sd3);
        send_item(OP_LOAD, 32'sd3);
        send_item(OP_LOAD, -32'sd3);
        send_item(OP_LOAD, 32'sd3);
        send_item(OP_LOAD, 32'sd0);
        send_item(OP_LOAD, -32'sd3);
        send_item(OP_LOAD, 32'sd7);
        send_item(OP_LOAD, 32'sd3);
        send_item(OP_LOAD, -32'sd8);
        wait_idle();
        cfg_write(CFG_ROWS, 5'd0);
        cfg_write(CFG_COLS, 5'd2);
        send_item(OP_UNLOAD, rand_value());
        send_item(OP_UNLOAD, rand_value());

        // long receiver hold-off while unloads keep coming
        run_matrix(1'b1, 5'd3, 5'd5, 1'b0, 1'b1);
        work_items = 0;

        // random matrices
        while (work_items < 150)
        begin
            r = pick_dim();
            c = pick_dim();
            if (places.eff_dim(r, MAX_R) * places.eff_dim(c, MAX_C) > 32)
                c = CFG_DATA_W'($urandom_range(0, 2));
            run_matrix($urandom_range(0, 9) < 6, r, c, $urandom_range(0, 7) == 0, 1'b0);
        end

        // full size with no idling on either side
        steady = 1'b1;
        run_matrix(1'b1, 5'd31, 5'd16, 1'b0, 1'b0);
        steady = 1'b0;
        run_matrix(1'b1, 5'd1, 5'd1, 1'b0, 1'b0);
        run_matrix(1'b1, 5'd16, 5'd0, 1'b0, 1'b0);

        wait_idle();
        repeat (4) @(posedge clk);
        if (places.close_out() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/sos_pkg.sv
design/sos_cell.sv
design/sos_walk.sv
design/spiral_order_sort.sv
tb/sv/tb_spiral_order_sort.sv
